### src/behm_pkg.sv
// Shared types, constants and fixed-point helpers for the brick element matrix block.
// No dependencies; every design module but the checker imports this package.
`default_nettype none

package behm_pkg;

  localparam int unsigned QueueDepth = 2;

  // Reciprocals for the constant divides in the entry pipeline.
  localparam int unsigned ShiftM = 35;
  localparam int unsigned ShiftK = 34;
  localparam logic [27:0] RecipM = 28'((64'd1 << ShiftM) / 64'd216);
  localparam logic [28:0] RecipK = 29'((64'd1 << ShiftK) / 64'd36);

  localparam logic signed [31:0] SatMax = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] SatMin = 32'sh8000_0000;

  // Per-element values handed from the front end to the entry pipeline.
  typedef struct packed {
    logic               bad;
    logic [30:0]        vol;
    logic [30:0]        kx;
    logic [30:0]        ky;
    logic [30:0]        kz;
    logic signed [31:0] lam;
    logic signed [31:0] cw;
    logic signed [31:0] sw;
  } item_t;

  // Q16.16 product rescale: round half away from zero, then saturate.
  function automatic logic signed [31:0] qmul_post(input logic signed [63:0] prod);
    logic        neg;
    logic [63:0] mag;
    logic [47:0] q;
    logic signed [31:0] res;
    neg = prod[63];
    mag = neg ? 64'(-prod) : 64'(prod);
    q   = 48'((mag + 64'd32768) >> 16);
    if (neg) begin
      if (q > 48'd2147483648) res = SatMin;
      else res = 32'(48'd0 - q);
    end else begin
      if (q > 48'd2147483647) res = SatMax;
      else res = 32'(q);
    end
    return res;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] res;
    if (v > 33'sh0_7FFF_FFFF) res = SatMax;
    else if (v < -33'sh0_8000_0000) res = SatMin;
    else res = 32'(v);
    return res;
  endfunction

endpackage

`default_nettype wire

### src/brick_element_harmonic_matrices_top.sv
// Top level of the brick element matrix block: front end, element queue, entry pipeline.
// Depends on behm_pkg, behm_front, behm_div, behm_fifo and behm_back.
//
//   channel  | handshake               | payload
//   ---------+-------------------------+----------------------------------------------
//   element  | start_i, busy_o         | width_x/y/z_i, conductivity_i, damping_i,
//            |                         | capacity_i
//   entry    | out_valid_o (strobe)    | row_o, col_o, p_value_o, c_value_o,
//            |                         | bad_size_o, last_o
//   config   | cfg_we_i                | cfg_wdata_i (angular frequency)
//
// An element gives 64 beats, one per cycle, (0,0) first and (7,7) marked by last_o.
// The front end holds busy_o through seven multiplies and the 31-step dividers, which start
// with the volume multiply and end at once when every quotient saturates; the entry pipeline
// streams queued elements back to back, 64 beats each. Once the dividers are done, the front
// end waits only while the queue is full. Results cannot be stalled. Reset sets the angular
// frequency to 1.0 and empties the queue.
`default_nettype none

module brick_element_harmonic_matrices_top #(
  parameter int unsigned QueueDepth = behm_pkg::QueueDepth
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  output logic                    busy_o,
  input  wire logic [30:0]        width_x_i,
  input  wire logic [30:0]        width_y_i,
  input  wire logic [30:0]        width_z_i,
  input  wire logic signed [31:0] conductivity_i,
  input  wire logic signed [31:0] damping_i,
  input  wire logic signed [31:0] capacity_i,
  input  wire logic               cfg_we_i,
  input  wire logic [30:0]        cfg_wdata_i,
  output logic                    out_valid_o,
  output logic [2:0]              row_o,
  output logic [2:0]              col_o,
  output logic signed [31:0]      p_value_o,
  output logic signed [31:0]      c_value_o,
  output logic                    bad_size_o,
  output logic                    last_o
);
  import behm_pkg::*;

  logic [30:0] omega_q;
  item_t push_item, head_item;
  logic push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) omega_q <= 31'd65536;
    else if (cfg_we_i) omega_q <= cfg_wdata_i;
  end

  behm_front u_front (
    .clk_i, .rst_ni, .start_i,
    .width_x_i, .width_y_i, .width_z_i,
    .conductivity_i, .damping_i, .capacity_i,
    .omega_i(omega_q), .full_i(full),
    .busy_o, .push_o(push), .item_o(push_item)
  );

  behm_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk_i, .rst_ni, .push_i(push), .data_i(push_item), .pop_i(pop),
    .head_o(head_item), .full_o(full), .empty_o(empty)
  );

  behm_back u_back (
    .clk_i, .rst_ni, .empty_i(empty), .head_i(head_item), .pop_o(pop),
    .out_valid_o, .row_o, .col_o, .p_value_o, .c_value_o, .bad_size_o, .last_o
  );

endmodule

`default_nettype wire

### src/behm_div.sv
// Bit-serial rounded Q16.16 divider: sat(round(num * 2^16 / den)), num >= 0, den > 0.
// Uses behm_pkg for the saturation constant.
`default_nettype none

module behm_div (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [30:0] num_i,
  input  wire logic [30:0] den_i,
  output logic             busy_o,
  output logic [30:0]      quot_o
);
  import behm_pkg::*;

  logic [30:0] rem_q, rem_d;
  logic [30:0] sh_q, sh_d;     // dividend low bits in, quotient bits out
  logic [30:0] den_q;
  logic [4:0]  cnt_q, cnt_d;
  logic        busy_q, busy_d;
  logic        ovf_q, ovf_d;

  logic [47:0] x_full;
  logic [31:0] trial;
  logic        ge;

  assign x_full = {1'b0, num_i, 16'd0} + {18'd0, den_i[30:1]};
  assign trial  = {rem_q, sh_q[30]};
  assign ge     = trial >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    sh_d   = sh_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    ovf_d  = ovf_q;
    if (start_i) begin
      // quotient of 2^31 or more saturates straight away
      ovf_d  = {14'd0, x_full[47:31]} >= den_i;
      rem_d  = 31'(x_full[47:31]);
      sh_d   = x_full[30:0];
      cnt_d  = 5'd31;
      busy_d = !ovf_d;
    end else if (busy_q) begin
      rem_d = ge ? 31'(trial - {1'b0, den_q}) : trial[30:0];
      sh_d  = {sh_q[29:0], ge};
      cnt_d = cnt_q - 5'd1;
      if (cnt_q == 5'd1) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 5'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    sh_q  <= sh_d;
    ovf_q <= ovf_d;
    if (start_i) den_q <= den_i;
  end

  assign busy_o = busy_q;
  assign quot_o = ovf_q ? SatMax[30:0] : sh_q;

endmodule

`default_nettype wire

### src/behm_front.sv
// Front end: takes an element, forms volume, stiffness factors and omega terms.
// One shared Q16.16 multiplier plus three behm_div units; uses behm_pkg.
`default_nettype none

module behm_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic [30:0]        width_x_i,
  input  wire logic [30:0]        width_y_i,
  input  wire logic [30:0]        width_z_i,
  input  wire logic signed [31:0] conductivity_i,
  input  wire logic signed [31:0] damping_i,
  input  wire logic signed [31:0] capacity_i,
  input  wire logic [30:0]        omega_i,
  input  wire logic               full_i,
  output logic                    busy_o,
  output logic                    push_o,
  output behm_pkg::item_t         item_o
);
  import behm_pkg::*;

  typedef enum logic [2:0] {
    StIdle = 3'b001,
    StMul  = 3'b010,
    StDiv  = 3'b100
  } state_e;

  localparam logic [2:0] StepHxy = 3'd0;
  localparam logic [2:0] StepHyz = 3'd1;
  localparam logic [2:0] StepHxz = 3'd2;
  localparam logic [2:0] StepVol = 3'd3;
  localparam logic [2:0] StepW2  = 3'd4;
  localparam logic [2:0] StepCw  = 3'd5;
  localparam logic [2:0] StepSw  = 3'd6;

  state_e state_q, state_d;
  logic [2:0] step_q, step_d;

  logic [30:0] hx_q, hy_q, hz_q;
  logic signed [31:0] lam_q, sig_q, chi_q;
  logic bad_q;
  logic signed [31:0] hxy_q, hyz_q, hxz_q, vol_q, w2_q, cw_q, sw_q;

  logic signed [31:0] op_a, op_b, mul_res;
  logic signed [63:0] prod;
  logic div_start;
  logic [2:0] div_busy;
  logic [30:0] kx, ky, kz;

  always_comb begin
    op_a = '0;
    op_b = '0;
    case (step_q)
      StepHxy: begin op_a = {1'b0, hx_q}; op_b = {1'b0, hy_q}; end
      StepHyz: begin op_a = {1'b0, hy_q}; op_b = {1'b0, hz_q}; end
      StepHxz: begin op_a = {1'b0, hx_q}; op_b = {1'b0, hz_q}; end
      StepVol: begin op_a = hxy_q;        op_b = {1'b0, hz_q}; end
      StepW2:  begin op_a = {1'b0, omega_i}; op_b = {1'b0, omega_i}; end
      StepCw:  begin op_a = w2_q;         op_b = chi_q; end
      StepSw:  begin op_a = {1'b0, omega_i}; op_b = sig_q; end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod    = op_a * op_b;
  assign mul_res = qmul_post(prod);

  // edge products are all in place once the volume step runs
  assign div_start = (state_q == StMul) && (step_q == StepVol);

  behm_div u_div_x (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(hyz_q[30:0]), .den_i(hx_q),
    .busy_o(div_busy[0]), .quot_o(kx)
  );
  behm_div u_div_y (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(hxz_q[30:0]), .den_i(hy_q),
    .busy_o(div_busy[1]), .quot_o(ky)
  );
  behm_div u_div_z (
    .clk_i, .rst_ni, .start_i(div_start), .num_i(hxy_q[30:0]), .den_i(hz_q),
    .busy_o(div_busy[2]), .quot_o(kz)
  );

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    push_o  = 1'b0;
    case (state_q)
      StIdle: begin
        if (start_i) begin
          state_d = StMul;
          step_d  = StepHxy;
        end
      end
      StMul: begin
        step_d = step_q + 3'd1;
        if (step_q == StepSw) state_d = StDiv;
      end
      StDiv: begin
        if (div_busy == 3'b000 && !full_i) begin
          push_o  = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      step_q  <= StepHxy;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && start_i) begin
      hx_q  <= width_x_i;
      hy_q  <= width_y_i;
      hz_q  <= width_z_i;
      lam_q <= conductivity_i;
      sig_q <= damping_i;
      chi_q <= capacity_i;
      bad_q <= (width_x_i == '0) || (width_y_i == '0) || (width_z_i == '0);
    end
    if (state_q == StMul) begin
      case (step_q)
        StepHxy: hxy_q <= mul_res;
        StepHyz: hyz_q <= mul_res;
        StepHxz: hxz_q <= mul_res;
        StepVol: vol_q <= mul_res;
        StepW2:  w2_q  <= mul_res;
        StepCw:  cw_q  <= mul_res;
        StepSw:  sw_q  <= mul_res;
        default: ;
      endcase
    end
  end

  // a zero edge zeroes volume and stiffness, so every entry comes out zero
  always_comb begin
    item_o.bad = bad_q;
    item_o.vol = bad_q ? '0 : vol_q[30:0];
    item_o.kx  = bad_q ? '0 : kx;
    item_o.ky  = bad_q ? '0 : ky;
    item_o.kz  = bad_q ? '0 : kz;
    item_o.lam = lam_q;
    item_o.cw  = cw_q;
    item_o.sw  = sw_q;
  end

  assign busy_o = (state_q != StIdle);

endmodule

`default_nettype wire

### src/behm_fifo.sv
// Short queue of prepared elements between front end and entry pipeline.
// Entry type from behm_pkg.
`default_nettype none

module behm_fifo #(
  parameter int unsigned Depth = behm_pkg::QueueDepth
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push_i,
  input  behm_pkg::item_t data_i,
  input  wire logic       pop_i,
  output behm_pkg::item_t head_o,
  output logic            full_o,
  output logic            empty_o
);
  import behm_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  item_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= nxt(wr_q);
      if (pop_i) rd_q <= nxt(rd_q);
      if (push_i && !pop_i) cnt_q <= cnt_q + CntW'(1);
      else if (pop_i && !push_i) cnt_q <= cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  assign head_o  = mem_q[rd_q];
  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);

endmodule

`default_nettype wire

### src/behm_back.sv
// Entry pipeline: walks the 64 node pairs of an element, one entry per cycle.
// Five register stages; item type and rounding helpers from behm_pkg.
`default_nettype none

module behm_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               empty_i,
  input  behm_pkg::item_t         head_i,
  output logic                    pop_o,
  output logic                    out_valid_o,
  output logic [2:0]              row_o,
  output logic [2:0]              col_o,
  output logic signed [31:0]      p_value_o,
  output logic signed [31:0]      c_value_o,
  output logic                    bad_size_o,
  output logic                    last_o
);
  import behm_pkg::*;

  item_t cur_q;
  logic [5:0] idx_q;
  logic run_q;

  assign pop_o = !empty_i && (!run_q || idx_q == 6'd63);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      idx_q <= '0;
    end else if (pop_o) begin
      run_q <= 1'b1;
      idx_q <= '0;
    end else if (run_q) begin
      idx_q <= idx_q + 6'd1;
      if (idx_q == 6'd63) run_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) cur_q <= head_i;
  end

  // stage 0: per-axis agreement selects the power-of-two weights
  logic [2:0] eq;
  logic [1:0] shm_lo, shx, shy, shz;
  logic [1:0] shm;
  assign eq     = ~(idx_q[5:3] ^ idx_q[2:0]);
  assign shx    = {1'b0, eq[1]} + {1'b0, eq[2]};
  assign shy    = {1'b0, eq[0]} + {1'b0, eq[2]};
  assign shz    = {1'b0, eq[0]} + {1'b0, eq[1]};
  assign shm_lo = shx;
  assign shm    = shm_lo;

  logic        v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [2:0]  r1_q, r2_q, r3_q, r4_q, r5_q;
  logic [2:0]  c1_q, c2_q, c3_q, c4_q, c5_q;
  logic        l1_q, l2_q, l3_q, l4_q, l5_q;
  logic        b1_q, b2_q, b3_q, b4_q, b5_q;
  logic [2:0]  s1_q, s2_q;
  logic signed [31:0] lam1_q, lam2_q, lam3_q;
  logic signed [31:0] cw1_q, cw2_q, cw3_q;
  logic signed [31:0] sw1_q, sw2_q, sw3_q;
  logic [34:0] ym1_q, ym2_q;
  logic [33:0] yx1_q, yy1_q, yz1_q, yx2_q, yy2_q, yz2_q;
  logic [27:0] qm2_q;
  logic [28:0] qx2_q, qy2_q, qz2_q;
  logic [27:0] m3_q;
  logic signed [31:0] gs3_q;
  logic signed [63:0] plg4_q, pcm4_q, psm4_q;
  logic signed [31:0] p5_q, c5v_q;

  logic [34:0] ym0;
  logic [33:0] yx0, yy0, yz0;
  // vol*2^(matches) with half of 216 added for rounding; eq count = shx + eq[0]
  assign ym0 = (35'(cur_q.vol) << ({1'b0, shm} + {2'b0, eq[0]})) + 35'd108;
  assign yx0 = (34'(cur_q.kx) << shx) + 34'd18;
  assign yy0 = (34'(cur_q.ky) << shy) + 34'd18;
  assign yz0 = (34'(cur_q.kz) << shz) + 34'd18;

  // stage 1: reciprocal multiplies
  logic [62:0] pm, px, py, pz;
  assign pm = 63'(ym1_q) * 63'(RecipM);
  assign px = 63'(yx1_q) * 63'(RecipK);
  assign py = 63'(yy1_q) * 63'(RecipK);
  assign pz = 63'(yz1_q) * 63'(RecipK);

  // stage 2: estimate is exact or one short; fix it up and sum the stiffness terms
  logic [34:0] rm;
  logic [33:0] rx, ry, rz;
  logic [27:0] mfin;
  logic [28:0] tx, ty, tz;
  logic signed [31:0] tx_s, ty_s, tz_s, gs;
  assign rm   = ym2_q - 35'(qm2_q) * 35'd216;
  assign rx   = yx2_q - 34'(qx2_q) * 34'd36;
  assign ry   = yy2_q - 34'(qy2_q) * 34'd36;
  assign rz   = yz2_q - 34'(qz2_q) * 34'd36;
  assign mfin = qm2_q + 28'(rm >= 35'd216);
  assign tx   = qx2_q + 29'(rx >= 34'd36);
  assign ty   = qy2_q + 29'(ry >= 34'd36);
  assign tz   = qz2_q + 29'(rz >= 34'd36);
  assign tx_s = s2_q[0] ? $signed({3'b0, tx}) : -$signed({3'b0, tx});
  assign ty_s = s2_q[1] ? $signed({3'b0, ty}) : -$signed({3'b0, ty});
  assign tz_s = s2_q[2] ? $signed({3'b0, tz}) : -$signed({3'b0, tz});
  // each term stays below 2^29, so the sum cannot leave the 32-bit range
  assign gs   = tx_s + ty_s + tz_s;

  // stage 3: coefficient products
  logic signed [28:0] m_s;
  assign m_s = $signed({1'b0, m3_q});

  // stage 4: rescale and combine
  logic signed [31:0] pa, pb, cv;
  assign pa = qmul_post(plg4_q);
  assign pb = qmul_post(pcm4_q);
  assign cv = qmul_post(psm4_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= run_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    r1_q <= idx_q[5:3];  c1_q <= idx_q[2:0];
    l1_q <= (idx_q == 6'd63);
    b1_q <= cur_q.bad;
    s1_q <= eq;
    lam1_q <= cur_q.lam; cw1_q <= cur_q.cw; sw1_q <= cur_q.sw;
    ym1_q <= ym0; yx1_q <= yx0; yy1_q <= yy0; yz1_q <= yz0;

    r2_q <= r1_q; c2_q <= c1_q; l2_q <= l1_q; b2_q <= b1_q; s2_q <= s1_q;
    lam2_q <= lam1_q; cw2_q <= cw1_q; sw2_q <= sw1_q;
    ym2_q <= ym1_q; yx2_q <= yx1_q; yy2_q <= yy1_q; yz2_q <= yz1_q;
    qm2_q <= pm[62:35];
    qx2_q <= px[62:34];
    qy2_q <= py[62:34];
    qz2_q <= pz[62:34];

    r3_q <= r2_q; c3_q <= c2_q; l3_q <= l2_q; b3_q <= b2_q;
    lam3_q <= lam2_q; cw3_q <= cw2_q; sw3_q <= sw2_q;
    m3_q <= mfin;
    gs3_q <= gs;

    r4_q <= r3_q; c4_q <= c3_q; l4_q <= l3_q; b4_q <= b3_q;
    plg4_q <= lam3_q * gs3_q;
    pcm4_q <= cw3_q * m_s;
    psm4_q <= sw3_q * m_s;

    r5_q <= r4_q; c5_q <= c4_q; l5_q <= l4_q; b5_q <= b4_q;
    p5_q  <= sat33({pa[31], pa} - {pb[31], pb});
    c5v_q <= cv;
  end

  assign out_valid_o = v5_q;
  assign row_o       = r5_q;
  assign col_o       = c5_q;
  assign p_value_o   = p5_q;
  assign c_value_o   = c5v_q;
  assign bad_size_o  = b5_q;
  assign last_o      = v5_q && l5_q;

endmodule

`default_nettype wire

### src/behm_checker.sv
// Port-level checks on the brick element matrix block, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module behm_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               start_i,
  input wire logic               busy_o,
  input wire logic               out_valid_o,
  input wire logic [2:0]         row_o,
  input wire logic [2:0]         col_o,
  input wire logic signed [31:0] p_value_o,
  input wire logic signed [31:0] c_value_o,
  input wire logic               bad_size_o,
  input wire logic               last_o
);

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("busy not raised after an element was taken");

  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> out_valid_o && row_o == 3'd7 && col_o == 3'd7)
    else $error("last beat not at (7,7)");

  a_beat_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |=>
      out_valid_o && {row_o, col_o} == 6'($past({row_o, col_o}) + 6'd1))
    else $error("entry beats not consecutive");

  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_size_o |-> p_value_o == 32'sd0 && c_value_o == 32'sd0)
    else $error("non-zero value on a bad-size beat");

  a_bad_steady: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |=> bad_size_o == $past(bad_size_o))
    else $error("bad_size changed within an element");

endmodule

bind brick_element_harmonic_matrices_top behm_checker u_behm_checker (
  .clk_i, .rst_ni, .start_i, .busy_o, .out_valid_o, .row_o, .col_o,
  .p_value_o, .c_value_o, .bad_size_o, .last_o
);

`default_nettype wire

### bench/tb_brick_element_harmonic_matrices_top.sv
// Self-checking bench for the brick element matrix block: directed table, then random elements.
// Depends on behm_pkg and brick_element_harmonic_matrices_top; predicts all 64 beats per element.
`default_nettype none

module tb_brick_element_harmonic_matrices_top;

  localparam longint QOne      = 65536;
  localparam longint QMax      = 64'sd2147483647;
  localparam longint QMin      = -64'sd2147483648;
  localparam int     DrainWait = 120;
  localparam int     StallLimit = 3000;

  typedef struct {
    logic [2:0]         row;
    logic [2:0]         col;
    logic signed [31:0] p;
    logic signed [31:0] c;
    logic               bad;
    logic               last;
  } mat_entry_t;

  typedef struct packed {
    logic [30:0]        hx;
    logic [30:0]        hy;
    logic [30:0]        hz;
    logic signed [31:0] lam;
    logic signed [31:0] sig;
    logic signed [31:0] chi;
    logic               zero_typed;  // all values read as zero without prediction
  } element_t;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               start;
  logic               busy;
  logic [30:0]        width_x, width_y, width_z;
  logic signed [31:0] conductivity, damping, capacity;
  logic               cfg_we;
  logic [30:0]        cfg_wdata;
  logic               out_valid;
  logic [2:0]         row, col;
  logic signed [31:0] p_value, c_value;
  logic               bad_size, last;

  mat_entry_t pending_entries[$];
  longint     omega_model;
  int         fail_count;
  int         stall_cycles;
  element_t   dir_tbl[14];

  brick_element_harmonic_matrices_top dut (
    .clk_i(clk), .rst_ni(rst_n), .start_i(start), .busy_o(busy),
    .width_x_i(width_x), .width_y_i(width_y), .width_z_i(width_z),
    .conductivity_i(conductivity), .damping_i(damping), .capacity_i(capacity),
    .cfg_we_i(cfg_we), .cfg_wdata_i(cfg_wdata),
    .out_valid_o(out_valid), .row_o(row), .col_o(col),
    .p_value_o(p_value), .c_value_o(c_value), .bad_size_o(bad_size), .last_o(last)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint sat_q(longint v);
    if (v > QMax) return QMax;
    if (v < QMin) return QMin;
    return v;
  endfunction

  // rounds half away from zero, den > 0
  function automatic longint round_div(longint num, longint den);
    longint mag;
    mag = (num < 0) ? -num : num;
    mag = (mag + den / 2) / den;
    return (num < 0) ? -mag : mag;
  endfunction

  function automatic longint q_mul(longint a, longint b);
    return sat_q(round_div(a * b, QOne));
  endfunction

  function automatic longint q_scale(longint v, longint k, longint d);
    return sat_q(round_div(v * k, d));
  endfunction

  task automatic predict_element(element_t e);
    longint hx, hy, hz, vol, kx, ky, kz, w2, cw, sw, m, gs;
    longint ax, ay, az, sx, sy, sz;
    logic bad;
    mat_entry_t ent;
    hx = longint'(e.hx);
    hy = longint'(e.hy);
    hz = longint'(e.hz);
    bad = (hx == 0) || (hy == 0) || (hz == 0);
    vol = 0; kx = 0; ky = 0; kz = 0;
    if (!bad) begin
      vol = q_mul(q_mul(hx, hy), hz);
      kx = sat_q(round_div(q_mul(hy, hz) * QOne, hx));
      ky = sat_q(round_div(q_mul(hx, hz) * QOne, hy));
      kz = sat_q(round_div(q_mul(hx, hy) * QOne, hz));
    end
    w2 = q_mul(omega_model, omega_model);
    cw = q_mul(w2, longint'(e.chi));
    sw = q_mul(omega_model, longint'(e.sig));
    for (int i = 0; i < 8; i++) begin
      for (int j = 0; j < 8; j++) begin
        ent.row = 3'(i);
        ent.col = 3'(j);
        ent.bad = bad;
        ent.last = (i == 7) && (j == 7);
        ent.p = '0;
        ent.c = '0;
        if (!bad && !e.zero_typed) begin
          ax = ((i ^ j) & 1) == 0 ? 2 : 1;
          ay = ((i ^ j) & 2) == 0 ? 2 : 1;
          az = ((i ^ j) & 4) == 0 ? 2 : 1;
          sx = (ax == 2) ? 1 : -1;
          sy = (ay == 2) ? 1 : -1;
          sz = (az == 2) ? 1 : -1;
          m = q_scale(vol, ax * ay * az, 216);
          gs = sat_q(q_scale(kx, sx * ay * az, 36) + q_scale(ky, ax * sy * az, 36)
                     + q_scale(kz, ax * ay * sz, 36));
          ent.p = 32'(sat_q(q_mul(longint'(e.lam), gs) - q_mul(cw, m)));
          ent.c = 32'(q_mul(sw, m));
        end
        pending_entries.push_back(ent);
      end
    end
  endtask

  // leaves start high on return so a back-to-back beat needs no second assignment
  task automatic send_element(element_t e, int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    width_x <= e.hx; width_y <= e.hy; width_z <= e.hz;
    conductivity <= e.lam; damping <= e.sig; capacity <= e.chi;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    predict_element(e);
  endtask

  task automatic drain_and_set_omega(logic [30:0] w);
    start <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_we <= 1'b0;
    omega_model = longint'(w);
  endtask

  function automatic logic [30:0] rand_width();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 75) return 31'($urandom_range(1 << 12, 1 << 19));
    if (pick < 80) return 31'h7FFF_FFFF;
    return 31'($urandom);
  endfunction

  function automatic logic signed [31:0] rand_coef();
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < 5) return 32'($urandom_range(0, 1 << 19)) - 32'(1 << 18);
    if (pick == 5) return SatMaxOrMin();
    return 32'($urandom);
  endfunction

  function automatic logic signed [31:0] SatMaxOrMin();
    return $urandom_range(0, 1) ? behm_pkg::SatMax : behm_pkg::SatMin;
  endfunction

  // result side: compare each beat with the oldest prediction, plus the stall watchdog
  always @(posedge clk) begin
    mat_entry_t want;
    if (rst_n) begin
      if ((start && !busy) || out_valid || cfg_we) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
        $display("TEST FAILED");
        $finish;
      end
      if (out_valid) begin
        if (pending_entries.size() == 0) begin
          $error("unexpected beat row=%0d col=%0d", row, col);
          fail_count++;
        end else begin
          want = pending_entries.pop_front();
          if (row !== want.row) begin
            $error("row: expected %0d, got %0d", want.row, row);
            fail_count++;
          end
          if (col !== want.col) begin
            $error("col: expected %0d, got %0d", want.col, col);
            fail_count++;
          end
          if (p_value !== want.p) begin
            $error("p_value: expected %0d, got %0d", want.p, p_value);
            fail_count++;
          end
          if (c_value !== want.c) begin
            $error("c_value: expected %0d, got %0d", want.c, c_value);
            fail_count++;
          end
          if (bad_size !== want.bad) begin
            $error("bad_size: expected %0b, got %0b", want.bad, bad_size);
            fail_count++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            fail_count++;
          end
        end
      end
    end
  end

  initial begin
    logic [30:0] omegas[6];
    int burst, gap;
    element_t e;
    rst_n = 1'b0;
    start = 1'b0;
    width_x = '0; width_y = '0; width_z = '0;
    conductivity = '0; damping = '0; capacity = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    fail_count = 0;
    stall_cycles = 0;
    omega_model = QOne;

    // hx, hy, hz, lambda, sigma, chi, zero_typed
    dir_tbl[0]  = '{31'h1_0000, 31'h1_0000, 31'h1_0000, 32'sh1_0000, 32'sh1_0000,
                    32'sh1_0000, 1'b0};
    dir_tbl[1]  = '{31'h0, 31'h1_0000, 31'h1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 1'b1};
    dir_tbl[2]  = '{31'h1_0000, 31'h0, 31'h1_0000, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 1'b1};
    dir_tbl[3]  = '{31'h1_0000, 31'h1_0000, 31'h0, 32'sh1_0000, 32'sh1_0000, 32'sh1_0000, 1'b1};
    dir_tbl[4]  = '{31'h0, 31'h0, 31'h0, behm_pkg::SatMax, behm_pkg::SatMin,
                    behm_pkg::SatMax, 1'b1};
    dir_tbl[5]  = '{31'h2_0000, 31'h3_0000, 31'h8000, 32'sh0, 32'sh0, 32'sh0, 1'b1};
    dir_tbl[6]  = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, behm_pkg::SatMax,
                    behm_pkg::SatMax, behm_pkg::SatMax, 1'b0};
    dir_tbl[7]  = '{31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, behm_pkg::SatMin,
                    behm_pkg::SatMin, behm_pkg::SatMin, 1'b0};
    dir_tbl[8]  = '{31'h1, 31'h1, 31'h1, behm_pkg::SatMax, behm_pkg::SatMin,
                    behm_pkg::SatMin, 1'b0};
    dir_tbl[9]  = '{31'h1, 31'h7FFF_FFFF, 31'h1_0000, 32'sh1_0000, -32'sh1_0000,
                    32'sh2_0000, 1'b0};
    dir_tbl[10] = '{31'h8000, 31'h4_0000, 31'h1_8000, -32'sh3_0000, 32'sh0_4000,
                    -32'sh0_8000, 1'b0};
    dir_tbl[11] = '{31'h5555_5555, 31'h2AAA_AAAA, 31'h1234_5678, 32'sh5555_5555,
                    32'shAAAA_AAAA, 32'sh0F0F_0F0F, 1'b0};
    dir_tbl[12] = '{31'h2AAA_AAAA, 31'h5555_5555, 31'h6DCB_A987, 32'shAAAA_AAAA,
                    32'sh5555_5555, 32'shF0F0_F0F0, 1'b0};
    dir_tbl[13] = '{31'hC000, 31'hC000, 31'hC000, -32'sh1, 32'sh1, -32'sh1, 1'b0};

    omegas = '{31'h0, 31'h7FFF_FFFF, 31'h1_0000, 31'h0_8000, 31'($urandom), 31'h3_0000};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset value of omega first
    foreach (dir_tbl[k]) send_element(dir_tbl[k], (k % 3 == 0) ? 0 : $urandom_range(1, 9));
    drain_and_set_omega(31'h2_0000);
    foreach (dir_tbl[k]) send_element(dir_tbl[k], 0);

    foreach (omegas[ph]) begin
      drain_and_set_omega(omegas[ph]);
      for (int n = 0; n < 76; ) begin
        burst = $urandom_range(1, 12);
        for (int b = 0; b < burst && n < 76; b++, n++) begin
          e.hx = rand_width();
          e.hy = rand_width();
          e.hz = rand_width();
          e.lam = rand_coef();
          e.sig = rand_coef();
          e.chi = rand_coef();
          e.zero_typed = 1'b0;
          gap = (b == 0 && ph != 2) ? $urandom_range(1, 100) : 0;
          send_element(e, gap);
        end
      end
    end

    start <= 1'b0;
    while (pending_entries.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
    if (fail_count == 0 && pending_entries.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
